### hdl/volume_popup_qualifier_assert.svh
// Assertion macros shared by the checker of the volume popup qualifier.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef VOLUME_POPUP_QUALIFIER_ASSERT_SVH
`define VOLUME_POPUP_QUALIFIER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("volume popup qualifier check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("volume popup qualifier check failed");

`endif

### hdl/vpq_pkg.sv
// Shared types and constants of the volume popup qualifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package vpq_pkg;

    localparam int VOL_W        = 6;
    localparam int OVR_W        = 16;
    localparam int HOLD_W       = 10;
    localparam int MISS_W       = 8;
    localparam int STABLE_W     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 10;

    localparam int REASSERT_PERIOD = 20;
    localparam int PHASE_W         = $clog2(REASSERT_PERIOD);

    localparam logic [STABLE_W-1:0] STABLE_CAP = STABLE_W'(9);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL_LEN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLUME      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_READER_ATTACHED = CFG_IDX_W'(3);

    // Reset values of the configuration registers.
    localparam logic [HOLD_W-1:0] DWELL_LEN_RST  = HOLD_W'(28);
    localparam logic [MISS_W-1:0] FAIL_LIMIT_RST = MISS_W'(200);
    localparam logic [VOL_W-1:0]  MAX_VOLUME_RST = VOL_W'(40);

    typedef struct packed {
        logic [HOLD_W-1:0] dwell_len;
        logic [MISS_W-1:0] fail_limit;
        logic [VOL_W-1:0]  max_volume;
        logic              reader_attached;
    } vpq_cfg_t;

    typedef struct packed {
        logic              live_valid;
        logic [VOL_W-1:0]  live_volume;
        logic              override_valid;
        logic [OVR_W-1:0]  override_value;
        logic              layout_loaded;
    } vpq_item_t;

    // Value chosen for this tick by the selector.
    typedef struct packed {
        logic             have_val;
        logic [VOL_W-1:0] value;
        logic             rescan;
    } vpq_pick_t;

    typedef struct packed {
        logic             draw;
        logic [VOL_W-1:0] draw_volume;
        logic             hide;
        logic             reassert;
        logic             rescan;
    } vpq_result_t;

endpackage

`default_nettype wire

### hdl/vpq_select.sv
// Value selector of the volume popup qualifier: override clamp, live debouncer, miss counter.
// Depends on vpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpq_select
    import vpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire vpq_item_t item,
    input  wire vpq_cfg_t  cfg,
    input  wire logic      popup_shown,
    output vpq_pick_t      pick
);

    logic                cand_valid_reg, cand_valid_next;
    logic [VOL_W-1:0]    cand_value_reg, cand_value_next;
    logic [STABLE_W-1:0] stable_count_reg, stable_count_next;
    logic [MISS_W-1:0]   miss_count_reg, miss_count_next;

    logic              live_ok;
    logic              match;
    logic [MISS_W-1:0] miss_inc;

    always_comb
    begin
        cand_valid_next   = cand_valid_reg;
        cand_value_next   = cand_value_reg;
        stable_count_next = stable_count_reg;
        miss_count_next   = miss_count_reg;
        pick              = '0;

        live_ok  = item.live_valid && (item.live_volume <= cfg.max_volume);
        match    = cand_valid_reg && (cand_value_reg == item.live_volume);
        miss_inc = (miss_count_reg < cfg.fail_limit) ? miss_count_reg + MISS_W'(1)
                                                     : miss_count_reg;

        if (item.override_valid)
        begin
            // The override bypasses the debouncer and leaves its state alone.
            pick.have_val = 1'b1;
            if (item.override_value <= {{(OVR_W-VOL_W){1'b0}}, cfg.max_volume})
                pick.value = item.override_value[VOL_W-1:0];
            else
                pick.value = cfg.max_volume;
        end
        else if (!live_ok)
        begin
            miss_count_next = miss_inc;
            if ((miss_inc >= cfg.fail_limit) && cfg.reader_attached)
            begin
                miss_count_next   = '0;
                cand_valid_next   = 1'b0;
                cand_value_next   = '0;
                stable_count_next = '0;
                pick.rescan       = 1'b1;
            end
        end
        else
        begin
            miss_count_next = '0;
            if (match)
            begin
                if (stable_count_reg < STABLE_CAP)
                    stable_count_next = stable_count_reg + STABLE_W'(1);
            end
            else
            begin
                cand_valid_next   = 1'b1;
                cand_value_next   = item.live_volume;
                stable_count_next = '0;
            end
            // Once the candidate has repeated, it equals the sample itself.
            pick.value    = item.live_volume;
            pick.have_val = popup_shown || (stable_count_next != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_valid_reg   <= 1'b0;
            cand_value_reg   <= '0;
            stable_count_reg <= '0;
            miss_count_reg   <= '0;
        end
        else if (step)
        begin
            cand_valid_reg   <= cand_valid_next;
            cand_value_reg   <= cand_value_next;
            stable_count_reg <= stable_count_next;
            miss_count_reg   <= miss_count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/vpq_popup.sv
// Popup controller of the volume popup qualifier: seeding, draw, hold timer, reassert phase.
// Depends on vpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vpq_popup
    import vpq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire logic      layout_loaded,
    input  wire vpq_pick_t pick,
    input  wire vpq_cfg_t  cfg,
    output logic           popup_shown,
    output vpq_result_t    result
);

    logic               layout_ready_reg, layout_ready_next;
    logic               seeded_reg, seeded_next;
    logic [VOL_W-1:0]   last_shown_reg, last_shown_next;
    logic               shown_reg, shown_next;
    logic [HOLD_W-1:0]  dwell_cnt_reg, dwell_cnt_next;
    logic [PHASE_W-1:0] tick_phase_reg, tick_phase_next;

    logic [PHASE_W:0]   phase_inc;

    assign popup_shown = shown_reg;

    always_comb
    begin
        layout_ready_next = layout_ready_reg | layout_loaded;
        seeded_next       = seeded_reg & ~layout_loaded;
        last_shown_next   = last_shown_reg;
        shown_next        = shown_reg;
        dwell_cnt_next    = dwell_cnt_reg;
        result            = '0;
        result.rescan     = pick.rescan;

        if (layout_ready_next && pick.have_val)
        begin
            if (!seeded_next)
            begin
                // First value after a layout load only seeds.
                seeded_next     = 1'b1;
                last_shown_next = pick.value;
            end
            else if (pick.value != last_shown_reg)
            begin
                last_shown_next    = pick.value;
                result.draw        = 1'b1;
                result.draw_volume = pick.value;
                shown_next         = 1'b1;
                dwell_cnt_next     = cfg.dwell_len;
            end
        end

        if (shown_next)
        begin
            if (dwell_cnt_next != '0)
                dwell_cnt_next = dwell_cnt_next - HOLD_W'(1);
            else
            begin
                result.hide = 1'b1;
                shown_next  = 1'b0;
            end
        end

        phase_inc = {1'b0, tick_phase_reg} + (PHASE_W+1)'(1);
        if (phase_inc >= (PHASE_W+1)'(REASSERT_PERIOD))
            tick_phase_next = '0;
        else
            tick_phase_next = phase_inc[PHASE_W-1:0];

        result.reassert = shown_next && (tick_phase_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_ready_reg <= 1'b0;
            seeded_reg       <= 1'b0;
            last_shown_reg   <= '0;
            shown_reg        <= 1'b0;
            dwell_cnt_reg    <= '0;
            tick_phase_reg   <= '0;
        end
        else if (step)
        begin
            layout_ready_reg <= layout_ready_next;
            seeded_reg       <= seeded_next;
            last_shown_reg   <= last_shown_next;
            shown_reg        <= shown_next;
            dwell_cnt_reg    <= dwell_cnt_next;
            tick_phase_reg   <= tick_phase_next;
        end
    end

endmodule

`default_nettype wire

### hdl/volume_popup_qualifier.sv
// Top level of the volume popup qualifier: handshakes, configuration registers, pipeline.
// Depends on vpq_pkg, vpq_select and vpq_popup.
`timescale 1ns / 1ps
`default_nettype none

// The volume popup qualifier takes one word per poll tick and returns exactly one result
// word for it. A word is captured in an input register, evaluated combinationally by the
// selector and popup controller, and the result is placed in an output register, so a
// new word can be accepted every cycle while the output is not stalled. out_valid rises
// when the result of an accepted word is placed in the output register. The rate is one
// word per clock while the output is not stalled, set by the single state update per
// tick in the selector and popup controller. The input register still takes a word while
// a finished result waits, until both stages are full. Configuration writes are always
// accepted (cfg_ready is high) and should only be issued while no word is in flight;
// all four registers come out of reset with their defaults, reader_attached cleared.

module volume_popup_qualifier
    import vpq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  live_valid,
    input  wire logic [VOL_W-1:0]      live_volume,
    input  wire logic                  override_valid,
    input  wire logic [OVR_W-1:0]      override_value,
    input  wire logic                  layout_loaded,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       draw,
    output logic [VOL_W-1:0]           draw_volume,
    output logic                       hide,
    output logic                       reassert,
    output logic                       rescan,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    vpq_cfg_t    cfg_reg;
    vpq_item_t   item_reg;
    logic        item_valid_reg;
    vpq_result_t result_reg;
    logic        out_valid_reg;

    vpq_pick_t   pick;
    vpq_result_t result;
    logic        popup_shown;
    logic        step;

    // A captured word is evaluated whenever the output register is free or being emptied.
    assign step      = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || step;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dwell_len       <= DWELL_LEN_RST;
            cfg_reg.fail_limit      <= FAIL_LIMIT_RST;
            cfg_reg.max_volume      <= MAX_VOLUME_RST;
            cfg_reg.reader_attached <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DWELL_LEN:       cfg_reg.dwell_len       <= cfg_data[HOLD_W-1:0];
                CFG_FAIL_LIMIT:      cfg_reg.fail_limit      <= cfg_data[MISS_W-1:0];
                CFG_MAX_VOLUME:      cfg_reg.max_volume      <= cfg_data[VOL_W-1:0];
                CFG_READER_ATTACHED: cfg_reg.reader_attached <= cfg_data[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // Input register: control bit is reset, the payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.live_valid     <= live_valid;
            item_reg.live_volume    <= live_volume;
            item_reg.override_valid <= override_valid;
            item_reg.override_value <= override_value;
            item_reg.layout_loaded  <= layout_loaded;
        end
    end

    vpq_select u_select
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .popup_shown (popup_shown),
        .pick        (pick)
    );

    vpq_popup u_popup
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .layout_loaded (item_reg.layout_loaded),
        .pick          (pick),
        .cfg           (cfg_reg),
        .popup_shown   (popup_shown),
        .result        (result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign draw        = result_reg.draw;
    assign draw_volume = result_reg.draw_volume;
    assign hide        = result_reg.hide;
    assign reassert    = result_reg.reassert;
    assign rescan      = result_reg.rescan;

endmodule

`default_nettype wire

### hdl/vpq_checker.sv
// Port-level checker of the volume popup qualifier and its bind to the top level.
// Depends on vpq_pkg and volume_popup_qualifier_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "volume_popup_qualifier_assert.svh"

module vpq_port_props
    import vpq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_ready,
    input  wire logic             out_valid,
    input  wire logic             out_ready,
    input  wire logic             draw,
    input  wire logic [VOL_W-1:0] draw_volume,
    input  wire logic             hide,
    input  wire logic             reassert
);

    // A pending result is never withdrawn before it is taken.
    `VPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // With the output register empty the block must be able to take a word.
    `VPQ_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

    // The drawn value is zero whenever no draw is requested.
    `VPQ_ASSERT_NOW(a_volume_only_on_draw, out_valid && !draw, draw_volume == '0)

    // A hide leaves the popup hidden, so no reassert can come with it.
    `VPQ_ASSERT_NOW(a_no_reassert_on_hide, out_valid && hide, !reassert)

endmodule

bind volume_popup_qualifier vpq_port_props u_vpq_port_props
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .draw        (draw),
    .draw_volume (draw_volume),
    .hide        (hide),
    .reassert    (reassert)
);

`default_nettype wire

### tb/vpq_checker.sv
// Checker for the volume popup qualifier: watches all three channels, keeps its own
// model of the tick decisions and compares every result word. Depends on vpq_pkg.
`timescale 1ns / 1ps

module vpq_checker
    import vpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  live_valid,
    input  logic [VOL_W-1:0]      live_volume,
    input  logic                  override_valid,
    input  logic [OVR_W-1:0]      override_value,
    input  logic                  layout_loaded,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  draw,
    input  logic [VOL_W-1:0]      draw_volume,
    input  logic                  hide,
    input  logic                  reassert,
    input  logic                  rescan,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    words_seen,
    output int                    draws_seen,
    output int                    hides_seen,
    output int                    reasserts_seen,
    output int                    rescans_seen
);

    // Register copies.
    logic [HOLD_W-1:0]   dwell_len;
    logic [MISS_W-1:0]   fail_limit;
    logic [VOL_W-1:0]    max_volume;
    logic                reader_attached;

    // Tick state.
    logic                cand_valid;
    logic [VOL_W-1:0]    cand_value;
    logic [STABLE_W-1:0] stable_count;
    logic [MISS_W-1:0]   miss_count;
    logic                layout_ready;
    logic                seeded;
    logic [VOL_W-1:0]    last_shown;
    logic                popup_shown;
    logic [HOLD_W-1:0]   dwell_cnt;
    logic [PHASE_W-1:0]  tick_phase;

    vpq_result_t         tick_results_q[$];
    int                  mismatches;
    int                  results_seen;
    int                  words_n;
    int                  draws_n;
    int                  hides_n;
    int                  reasserts_n;
    int                  rescans_n;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at result %0d: %s got %0d, expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    // Advances the tick state by one poll tick and returns the decisions it makes.
    function automatic vpq_result_t qualify_tick(input vpq_item_t w);
        vpq_result_t      r;
        logic             have;
        logic [VOL_W-1:0] val;
        logic             sample_ok;
        r = '0;
        have = 1'b0;
        val = '0;
        if (w.layout_loaded)
        begin
            layout_ready = 1'b1;
            seeded = 1'b0;
        end
        if (w.override_valid)
        begin
            // The override bypasses the debouncer and leaves the miss counter alone.
            have = 1'b1;
            val = (w.override_value <= {{(OVR_W-VOL_W){1'b0}}, max_volume})
                  ? w.override_value[VOL_W-1:0] : max_volume;
        end
        else
        begin
            sample_ok = w.live_valid && (w.live_volume <= max_volume);
            if (!sample_ok)
            begin
                if (miss_count < fail_limit)
                    miss_count = miss_count + MISS_W'(1);
                if (miss_count >= fail_limit && reader_attached)
                begin
                    miss_count = '0;
                    cand_valid = 1'b0;
                    cand_value = '0;
                    stable_count = '0;
                    r.rescan = 1'b1;
                end
            end
            else
            begin
                miss_count = '0;
                if (cand_valid && cand_value == w.live_volume)
                begin
                    if (stable_count < STABLE_CAP)
                        stable_count = stable_count + STABLE_W'(1);
                end
                else
                begin
                    cand_valid = 1'b1;
                    cand_value = w.live_volume;
                    stable_count = '0;
                end
                if (popup_shown)
                begin
                    have = 1'b1;
                    val = w.live_volume;
                end
                else if (stable_count != '0)
                begin
                    have = 1'b1;
                    val = cand_value;
                end
            end
        end
        if (layout_ready && have)
        begin
            if (!seeded)
            begin
                seeded = 1'b1;
                last_shown = val;
            end
            else if (val != last_shown)
            begin
                last_shown = val;
                r.draw = 1'b1;
                r.draw_volume = val;
                popup_shown = 1'b1;
                dwell_cnt = dwell_len;
            end
        end
        if (popup_shown)
        begin
            if (dwell_cnt != '0)
                dwell_cnt = dwell_cnt - HOLD_W'(1);
            else
            begin
                r.hide = 1'b1;
                popup_shown = 1'b0;
            end
        end
        if (int'(tick_phase) + 1 >= REASSERT_PERIOD)
            tick_phase = '0;
        else
            tick_phase = tick_phase + PHASE_W'(1);
        if (popup_shown && tick_phase == '0)
            r.reassert = 1'b1;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vpq_result_t want;
        vpq_item_t   w;
        if (!rst_n)
        begin
            dwell_len = DWELL_LEN_RST;
            fail_limit = FAIL_LIMIT_RST;
            max_volume = MAX_VOLUME_RST;
            reader_attached = 1'b0;
            cand_valid = 1'b0;
            cand_value = '0;
            stable_count = '0;
            miss_count = '0;
            layout_ready = 1'b0;
            seeded = 1'b0;
            last_shown = '0;
            popup_shown = 1'b0;
            dwell_cnt = '0;
            tick_phase = '0;
            tick_results_q.delete();
            mismatches = 0;
            results_seen = 0;
            words_n = 0;
            draws_n = 0;
            hides_n = 0;
            reasserts_n = 0;
            rescans_n = 0;
        end
        else
        begin
            // Results first: a word accepted on this edge cannot have produced one yet.
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (tick_results_q.size() == 0)
                    report_mismatch("result word with nothing outstanding", 16'd1, 16'd0);
                else
                begin
                    want = tick_results_q.pop_front();
                    if (draw !== want.draw)
                        report_mismatch("draw", 16'(draw), 16'(want.draw));
                    if (draw_volume !== want.draw_volume)
                        report_mismatch("draw_volume", 16'(draw_volume),
                                        16'(want.draw_volume));
                    if (hide !== want.hide)
                        report_mismatch("hide", 16'(hide), 16'(want.hide));
                    if (reassert !== want.reassert)
                        report_mismatch("reassert", 16'(reassert), 16'(want.reassert));
                    if (rescan !== want.rescan)
                        report_mismatch("rescan", 16'(rescan), 16'(want.rescan));
                end
                draws_n += int'(draw === 1'b1);
                hides_n += int'(hide === 1'b1);
                reasserts_n += int'(reassert === 1'b1);
                rescans_n += int'(rescan === 1'b1);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DWELL_LEN:       dwell_len = cfg_data[HOLD_W-1:0];
                    CFG_FAIL_LIMIT:      fail_limit = cfg_data[MISS_W-1:0];
                    CFG_MAX_VOLUME:      max_volume = cfg_data[VOL_W-1:0];
                    CFG_READER_ATTACHED: reader_attached = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                w.live_valid = live_valid;
                w.live_volume = live_volume;
                w.override_valid = override_valid;
                w.override_value = override_value;
                w.layout_loaded = layout_loaded;
                tick_results_q.push_back(qualify_tick(w));
                words_n++;
            end
        end
        fail_count <= mismatches;
        pending <= tick_results_q.size();
        words_seen <= words_n;
        draws_seen <= draws_n;
        hides_seen <= hides_n;
        reasserts_seen <= reasserts_n;
        rescans_seen <= rescans_n;
    end

endmodule

### tb/tb.sv
// Top of the volume popup qualifier testbench: clock, reset, stimulus and verdict.
// Depends on vpq_pkg, the volume_popup_qualifier block and the vpq_checker module.
`timescale 1ns / 1ps

module tb;
    import vpq_pkg::*;

    // A stall this long outlasts the two word stages of the block many times over.
    localparam int LONG_STALL = 60;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  live_valid;
    logic [VOL_W-1:0]      live_volume;
    logic                  override_valid;
    logic [OVR_W-1:0]      override_value;
    logic                  layout_loaded;
    logic                  out_valid;
    logic                  out_ready;
    logic                  draw;
    logic [VOL_W-1:0]      draw_volume;
    logic                  hide;
    logic                  reassert;
    logic                  rescan;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int words_seen;
    int draws_seen;
    int hides_seen;
    int reasserts_seen;
    int rescans_seen;

    // Stimulus bookkeeping. The sender keeps its own view of the two settings that
    // shape the random sequences: the volume ceiling and the miss limit.
    int  max_setting;
    int  fail_setting;
    int  settings_run;
    bit  calm;
    int  stall_requests;
    int  stall_served;

    volume_popup_qualifier uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .live_valid     (live_valid),
        .live_volume    (live_volume),
        .override_valid (override_valid),
        .override_value (override_value),
        .layout_loaded  (layout_loaded),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .draw           (draw),
        .draw_volume    (draw_volume),
        .hide           (hide),
        .reassert       (reassert),
        .rescan         (rescan),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    vpq_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .live_valid     (live_valid),
        .live_volume    (live_volume),
        .override_valid (override_valid),
        .override_value (override_value),
        .layout_loaded  (layout_loaded),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .draw           (draw),
        .draw_volume    (draw_volume),
        .hide           (hide),
        .reassert       (reassert),
        .rescan         (rescan),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .words_seen     (words_seen),
        .draws_seen     (draws_seen),
        .hides_seen     (hides_seen),
        .reasserts_seen (reasserts_seen),
        .rescans_seen   (rescans_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one word and returns on the edge at which it is accepted. Now and then
    // the sender idles for a burst before the word, except in the calm stretch.
    task automatic send_word(input logic lv, input logic [VOL_W-1:0] vol, input logic ov,
                             input logic [OVR_W-1:0] oval, input logic ll);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 11);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        live_valid <= lv;
        live_volume <= vol;
        override_valid <= ov;
        override_value <= oval;
        layout_loaded <= ll;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stops offering words and waits until every outstanding result has come back.
    // The checker publishes its count through a register, so the first look waits for an edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Writes all four registers back to back while the block is idle.
    task automatic apply_setting(input int hold, input int fail, input int vmax, input int reader);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] vals [4];
        int                    i;
        wait_drained();
        idx[0] = CFG_DWELL_LEN;
        idx[1] = CFG_FAIL_LIMIT;
        idx[2] = CFG_MAX_VOLUME;
        idx[3] = CFG_READER_ATTACHED;
        vals[0] = CFG_DATA_W'(hold);
        vals[1] = CFG_DATA_W'(fail);
        vals[2] = CFG_DATA_W'(vmax);
        vals[3] = CFG_DATA_W'(reader);
        for (i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        max_setting = vmax;
        fail_setting = fail;
        settings_run++;
    endtask

    // Mostly a legal volume under the current ceiling, sometimes anything at all.
    function automatic logic [VOL_W-1:0] pick_volume();
        if ($urandom_range(0, 9) == 0)
            return VOL_W'($urandom_range(0, 63));
        return VOL_W'($urandom_range(0, max_setting));
    endfunction

    // Random traffic built from short sequences. Repeated live values are the bulk of
    // it, since only two equal samples in a row get past the debouncer while the popup
    // is hidden. Overrides, runs of missing samples, layout reloads and plain noise
    // make up the rest. Miss runs reach the limit often when it is small, and only
    // once in a while when it is large, so long limits do not eat the word budget.
    task automatic run_random(input int n_words);
        int               sent;
        int               kind;
        int               len;
        int               k;
        logic             lv;
        logic [VOL_W-1:0] v;
        logic [OVR_W-1:0] oval;
        sent = 0;
        while (sent < n_words)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                v = pick_volume();
                len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    send_word(1'b1, v, 1'b0, OVR_W'($urandom()), 1'b0);
                sent += len;
            end
            else if (kind < 55)
            begin
                send_word(1'b1, pick_volume(), 1'b0, OVR_W'($urandom()), 1'b0);
                sent++;
            end
            else if (kind < 70)
            begin
                if ($urandom_range(0, 2) == 0)
                    oval = OVR_W'($urandom());
                else
                    oval = OVR_W'($urandom_range(0, max_setting + 2));
                send_word(1'($urandom_range(0, 1)), VOL_W'($urandom_range(0, 63)), 1'b1,
                          oval, 1'b0);
                sent++;
            end
            else if (kind < 82)
            begin
                if (fail_setting <= 24)
                    len = $urandom_range(1, fail_setting + 2);
                else if ($urandom_range(0, 7) == 0)
                    len = fail_setting + 1;
                else
                    len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                begin
                    // A sample above the ceiling counts as missing, just like no sample.
                    lv = 1'($urandom_range(0, 1));
                    if (lv && max_setting < 63)
                        v = VOL_W'($urandom_range(max_setting + 1, 63));
                    else
                    begin
                        lv = 1'b0;
                        v = VOL_W'($urandom_range(0, 63));
                    end
                    send_word(lv, v, 1'b0, OVR_W'($urandom()), 1'b0);
                end
                sent += len;
            end
            else if (kind < 87)
            begin
                send_word(1'($urandom_range(0, 1)), pick_volume(), 1'($urandom_range(0, 1)),
                          OVR_W'($urandom_range(0, max_setting + 2)), 1'b1);
                sent++;
            end
            else
            begin
                send_word(1'($urandom_range(0, 1)), VOL_W'($urandom()),
                          1'($urandom_range(0, 1)), OVR_W'($urandom()),
                          ($urandom_range(0, 7) == 0));
                sent++;
            end
        end
    endtask

    // Receiver. It accepts freely most of the time, idles in short random bursts, and
    // serves a long hold-off whenever the main sequence asks for one. The long stall
    // is counted here, in cycles, so the sender keeps offering words meanwhile.
    initial
    begin
        out_ready = 1'b0;
        stall_served = 0;
        forever
        begin
            @(posedge clk);
            if (stall_served != stall_requests)
            begin
                stall_served = stall_requests;
                out_ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && rst_n && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Main sequence.
    initial
    begin
        int p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        live_valid = 1'b0;
        live_volume = '0;
        override_valid = 1'b0;
        override_value = '0;
        layout_loaded = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_DWELL_LEN;
        cfg_data = '0;
        calm = 1'b0;
        stall_requests = 0;
        settings_run = 1;
        max_setting = int'(MAX_VOLUME_RST);
        fail_setting = int'(FAIL_LIMIT_RST);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings. Before any layout load, stable
        // values are ignored; the first value after the load only seeds; the popup
        // then follows live values at once while shown.
        send_word(1'b1, 6'd10, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd10, 1'b0, 16'd0, 1'b0);
        send_word(1'b0, 6'd0, 1'b0, 16'd0, 1'b1);
        send_word(1'b1, 6'd12, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd12, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd20, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd20, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd21, 1'b0, 16'd0, 1'b0);
        // A sample above the ceiling, then overrides at the top, bottom and the ceiling.
        send_word(1'b1, 6'd63, 1'b0, 16'd0, 1'b0);
        send_word(1'b0, 6'd0, 1'b1, 16'hFFFF, 1'b0);
        send_word(1'b0, 6'd0, 1'b1, 16'd0, 1'b0);
        send_word(1'b0, 6'd0, 1'b1, 16'd40, 1'b0);
        send_word(1'b1, 6'd0, 1'b1, 16'd41, 1'b0);
        send_word(1'b1, 6'd40, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd0, 1'b0, 16'd0, 1'b0);
        // A layout reload in the same word as an override: the override only seeds.
        send_word(1'b1, 6'd5, 1'b1, 16'd7, 1'b1);
        send_word(1'b1, 6'd5, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'h3F, 1'b1, 16'hAAAA, 1'b0);
        send_word(1'b1, 6'h2A, 1'b1, 16'h5555, 1'b0);
        send_word(1'b1, 6'h15, 1'b0, 16'd0, 1'b0);

        // Zero hold with a one-tick miss limit and a reader attached: every missing
        // sample asks for a rescan and clears the debouncer, and a draw is hidden on
        // the same tick.
        apply_setting(0, 1, 63, 1);
        send_word(1'b0, 6'd0, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd63, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd63, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd3, 1'b0, 16'd0, 1'b0);
        send_word(1'b0, 6'd3, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd3, 1'b0, 16'd0, 1'b0);
        send_word(1'b1, 6'd3, 1'b0, 16'd0, 1'b0);
        run_random(200);

        // Longest hold and miss limit, smallest ceiling, no reader: the miss counter
        // parks at the limit and no rescan is ever asked for.
        apply_setting(1023, 255, 1, 0);
        run_random(200);

        // Short hold and limit. Midway the receiver holds off for a long stretch so
        // the block fills and stalls its input; later the sender pauses until every
        // outstanding result is back.
        apply_setting(5, 4, 40, 1);
        run_random(100);
        stall_requests++;
        run_random(60);
        wait_drained();
        run_random(60);

        // A moderate limit without a reader, full ceiling.
        apply_setting(3, 12, 63, 0);
        run_random(200);

        for (p = 0; p < 3; p++)
        begin
            apply_setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, 40),
                          $urandom_range(1, 30), $urandom_range(1, 63), $urandom_range(0, 1));
            run_random(200);
        end

        // Last stretch runs at full rate on both sides.
        apply_setting(2, 2, 50, 1);
        calm = 1'b1;
        run_random(200);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("covered %0d words over %0d register settings, with full-rate and stalled phases",
                 words_seen, settings_run);
        $display("results: %0d draws, %0d hides, %0d reasserts, %0d rescans",
                 draws_seen, hides_seen, reasserts_seen, rescans_seen);
        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run could take.
    initial
    begin
        #5000000;
        $display("timeout with %0d results outstanding", pending);
        $display("status: fail");
        $finish;
    end

endmodule
